// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GRM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define GRM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ===== rtl/core/grm_pkg.sv =====
`default_nettype none

package grm_pkg;

  localparam int unsigned MASK_WIDTH_MAX_DEF  = 8;
  localparam int unsigned MASK_HEIGHT_MAX_DEF = 8;

  localparam int unsigned COORD_W   = 3;
  localparam int unsigned TILE_W    = 8;
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  typedef struct packed {
    logic              present;
    logic [TILE_W-1:0] col;
    logic [TILE_W-1:0] row;
  } cell_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] u_start;
    logic [COORD_W-1:0] v_start;
    logic [COORD_W-1:0] u_end;
    logic [COORD_W-1:0] v_end;
    logic [TILE_W-1:0]  tile_col;
    logic [TILE_W-1:0]  tile_row;
    logic               last;
  } rect_t;

endpackage

`default_nettype wire

// ===== rtl/core/grm_ram.sv =====
`default_nettype none

module grm_ram
  import grm_pkg::*;
#(
  parameter int unsigned WIDTH = $bits(cell_t),
  parameter int unsigned DEPTH = MASK_WIDTH_MAX_DEF * MASK_HEIGHT_MAX_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/grm_merge.sv =====
`default_nettype none

module grm_merge
  import grm_pkg::*;
#(
  parameter int unsigned MASK_WIDTH_MAX  = MASK_WIDTH_MAX_DEF,
  parameter int unsigned MASK_HEIGHT_MAX = MASK_HEIGHT_MAX_DEF,
  localparam int unsigned DEPTH = MASK_WIDTH_MAX * MASK_HEIGHT_MAX,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              kick_i,
  input  wire logic [SIZE_W-1:0] width_i,
  input  wire logic [SIZE_W-1:0] height_i,
  output logic      [AW-1:0]     rd_addr_o,
  output logic                   clr_we_o,
  input  wire cell_t             rd_data_i,
  output logic                   busy_o,
  output logic                   out_strobe_o,
  output rect_t                  out_rect_o
);

  localparam int unsigned LIN_W = COORD_W + SIZE_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_EV  = 4'd2;
  localparam logic [3:0] S_RIGHT_RD = 4'd3;
  localparam logic [3:0] S_RIGHT_EV = 4'd4;
  localparam logic [3:0] S_DOWN_RD  = 4'd5;
  localparam logic [3:0] S_DOWN_EV  = 4'd6;
  localparam logic [3:0] S_EMIT     = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;
  localparam logic [3:0] S_CLEAR    = 4'd9;

  logic [3:0]           state_q, state_d;
  logic [COORD_W-1:0]   u_q, u_d, v_q, v_d, u1_q, u1_d, v1_q, v1_d, xx_q, xx_d;
  logic [COORD_W-1:0]   yy_q, yy_d;
  logic [2*TILE_W-1:0]  tile_q, tile_d;
  rect_t                pend_q, pend_d, out_q, out_d;
  logic                 pend_valid_q, pend_valid_d;
  logic                 strobe_q, strobe_d;

  logic [COORD_W-1:0]   cur_row, cur_col;
  logic [LIN_W-1:0]     lin_addr;
  logic                 cell_live, cell_match;

  // True when x + k is still inside a dimension of size lim.
  function automatic logic fits(logic [COORD_W-1:0] x, logic [1:0] k,
                                logic [SIZE_W-1:0] lim);
    return (SIZE_W'(x) + SIZE_W'(k)) < lim;
  endfunction

  // Cell coordinates of the access in flight; RD and EV states share them.
  always_comb begin
    unique case (state_q) inside
      S_RIGHT_RD, S_RIGHT_EV: begin
        cur_row = v_q;
        cur_col = u1_q + COORD_W'(1);
      end
      S_DOWN_RD, S_DOWN_EV: begin
        cur_row = v1_q + COORD_W'(1);
        cur_col = xx_q;
      end
      S_CLEAR: begin
        cur_row = yy_q;
        cur_col = xx_q;
      end
      default: begin
        cur_row = v_q;
        cur_col = u_q;
      end
    endcase
  end

  // Shared address unit: row * width + column.
  assign lin_addr  = LIN_W'(cur_row) * LIN_W'(width_i) + LIN_W'(cur_col);
  assign rd_addr_o = lin_addr[AW-1:0];
  assign clr_we_o  = (state_q == S_CLEAR);

  assign cell_live  = rd_data_i.present;
  assign cell_match = cell_live && ({rd_data_i.col, rd_data_i.row} == tile_q);

  always_comb begin
    state_d      = state_q;
    u_d          = u_q;
    v_d          = v_q;
    u1_d         = u1_q;
    v1_d         = v1_q;
    xx_d         = xx_q;
    yy_d         = yy_q;
    tile_d       = tile_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    strobe_d     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (kick_i) begin
          u_d          = '0;
          v_d          = '0;
          pend_valid_d = 1'b0;
          state_d      = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_d = S_SCAN_EV;
      S_SCAN_EV: begin
        if (cell_live) begin
          tile_d = {rd_data_i.col, rd_data_i.row};
          u1_d   = u_q;
          v1_d   = v_q;
          xx_d   = u_q;
          if (fits(u_q, 2'd1, width_i)) begin
            state_d = S_RIGHT_RD;
          end else if (fits(v_q, 2'd1, height_i)) begin
            state_d = S_DOWN_RD;
          end else begin
            state_d = S_EMIT;
          end
        end else if (fits(u_q, 2'd1, width_i)) begin
          u_d     = u_q + COORD_W'(1);
          state_d = S_SCAN_RD;
        end else if (fits(v_q, 2'd1, height_i)) begin
          u_d     = '0;
          v_d     = v_q + COORD_W'(1);
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RIGHT_RD: state_d = S_RIGHT_EV;
      S_RIGHT_EV: begin
        v1_d = v_q;
        xx_d = u_q;
        if (cell_match && fits(u1_q, 2'd2, width_i)) begin
          u1_d    = u1_q + COORD_W'(1);
          state_d = S_RIGHT_RD;
        end else begin
          if (cell_match) begin
            u1_d = u1_q + COORD_W'(1);
          end
          state_d = fits(v_q, 2'd1, height_i) ? S_DOWN_RD : S_EMIT;
        end
      end
      S_DOWN_RD: state_d = S_DOWN_EV;
      S_DOWN_EV: begin
        if (!cell_match) begin
          state_d = S_EMIT;
        end else if (xx_q != u1_q) begin
          xx_d    = xx_q + COORD_W'(1);
          state_d = S_DOWN_RD;
        end else begin
          // Whole span of the next row matches: take the row.
          v1_d    = v1_q + COORD_W'(1);
          xx_d    = u_q;
          state_d = fits(v1_q, 2'd2, height_i) ? S_DOWN_RD : S_EMIT;
        end
      end
      S_EMIT: begin
        // Hold each rectangle back one step so the final one can carry last.
        strobe_d          = pend_valid_q;
        out_d             = pend_q;
        out_d.last        = 1'b0;
        pend_d.valid      = 1'b1;
        pend_d.u_start    = u_q;
        pend_d.v_start    = v_q;
        pend_d.u_end      = u1_q;
        pend_d.v_end      = v1_q;
        pend_d.tile_col   = tile_q[2*TILE_W-1:TILE_W];
        pend_d.tile_row   = tile_q[TILE_W-1:0];
        pend_d.last       = 1'b0;
        pend_valid_d      = 1'b1;
        xx_d              = u_q;
        yy_d              = v_q;
        state_d           = S_CLEAR;
      end
      S_CLEAR: begin
        // Zero one covered cell per cycle so later reads see it empty.
        if (xx_q != u1_q) begin
          xx_d = xx_q + COORD_W'(1);
        end else if (yy_q != v1_q) begin
          xx_d = u_q;
          yy_d = yy_q + COORD_W'(1);
        end else if (fits(u_q, 2'd1, width_i)) begin
          u_d     = u_q + COORD_W'(1);
          state_d = S_SCAN_RD;
        end else if (fits(v_q, 2'd1, height_i)) begin
          u_d     = '0;
          v_d     = v_q + COORD_W'(1);
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        strobe_d   = 1'b1;
        out_d      = pend_valid_q ? pend_q : '0;
        out_d.last = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      strobe_q     <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    v_q    <= v_d;
    u1_q   <= u1_d;
    v1_q   <= v1_d;
    xx_q   <= xx_d;
    yy_q   <= yy_d;
    tile_q <= tile_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign out_strobe_o = strobe_q;
  assign out_rect_o   = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/greedy_rectangle_merge_top.sv =====
`default_nettype none
`include "assert_macros.svh"

// Greedy rectangle merge over a tile mask of up to MASK_WIDTH_MAX x MASK_HEIGHT_MAX.
// Load: pulse start with one cell word (cell_present_i, tile_col_i, tile_row_i);
// it is taken at an edge where start is high and busy is low, in raster order,
// column fastest. Each accepted word loads one cell.
// The word that completes width_in_use x height_in_use cells starts the merge:
// busy rises the next cycle and stays high for the whole scan. The scan shares
// one address unit and the mask RAM: it reads and tests each mask cell, reads
// and tests cells while growing a rectangle right and then down, emits each
// rectangle, clears every cell it covers in the RAM and then finishes.
// The final word comes out in the same cycle that busy falls.
// Each rectangle appears for one cycle with rect_strobe_o; the last one of the
// mask carries last_rect_o, and an empty mask gives a single word with
// rect_valid_o low. The receiver cannot stall; every strobe word is final.
// Configuration: write width_in_use (index 0) or height_in_use (index 1) on the
// cfg channel, always ready, only while the block is idle. Values of 0 act as 1
// and values above the maximum act as the maximum.
// Reset clears the load count and the sequencer and sets both sizes to their
// maximum; mask contents stay undefined until loaded.
module greedy_rectangle_merge_top
  import grm_pkg::*;
#(
  parameter int unsigned MASK_WIDTH_MAX  = MASK_WIDTH_MAX_DEF,
  parameter int unsigned MASK_HEIGHT_MAX = MASK_HEIGHT_MAX_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 cell_present_i,
  input  wire logic [TILE_W-1:0]    tile_col_i,
  input  wire logic [TILE_W-1:0]    tile_row_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [SIZE_W-1:0]    cfg_data_i,
  output logic                      rect_strobe_o,
  output logic                      rect_valid_o,
  output logic [COORD_W-1:0]        u_start_o,
  output logic [COORD_W-1:0]        v_start_o,
  output logic [COORD_W-1:0]        u_end_o,
  output logic [COORD_W-1:0]        v_end_o,
  output logic [TILE_W-1:0]         rect_tile_col_o,
  output logic [TILE_W-1:0]         rect_tile_row_o,
  output logic                      last_rect_o
);

  localparam int unsigned DEPTH = MASK_WIDTH_MAX * MASK_HEIGHT_MAX;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned TOT_W = 2 * SIZE_W;
  localparam logic [SIZE_W-1:0] W_MAX = SIZE_W'(MASK_WIDTH_MAX);
  localparam logic [SIZE_W-1:0] H_MAX = SIZE_W'(MASK_HEIGHT_MAX);

  logic [SIZE_W-1:0] width_q, width_d, height_q, height_d;
  logic [SIZE_W-1:0] width_eff, height_eff;
  logic [TOT_W-1:0]  total;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W:0]    count_inc;
  logic              accept, mask_done, kick;
  cell_t             wr_cell, rd_cell, ram_wdata;
  logic [AW-1:0]     rd_addr, ram_waddr;
  logic              clr_we, ram_we;
  rect_t             rect;
  logic              merge_busy;
  logic              rect_zero;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [SIZE_W-1:0] max);
    if (v == '0) begin
      return SIZE_W'(1);
    end
    return (v > max) ? max : v;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_d  = cfg_data_i;
        CFG_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = clamp_size(width_q, W_MAX);
  assign height_eff = clamp_size(height_q, H_MAX);
  assign total      = TOT_W'(width_eff) * TOT_W'(height_eff);

  assign accept    = start && !busy;
  assign count_inc = (CNT_W + 1)'(count_q) + (CNT_W + 1)'(1);
  assign mask_done = TOT_W'(count_inc) >= total;
  assign kick      = accept && mask_done;

  // Restart the raster position once the mask is complete.
  assign count_d = accept ? (mask_done ? '0 : count_inc[CNT_W-1:0]) : count_q;

  assign wr_cell = cell_present_i ? cell_t'{present: 1'b1, col: tile_col_i, row: tile_row_i}
                                  : '0;

  // The merge owns the write port while busy; loads only happen while idle.
  assign ram_we    = accept || clr_we;
  assign ram_waddr = clr_we ? rd_addr : count_q[AW-1:0];
  assign ram_wdata = clr_we ? '0 : wr_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= W_MAX;
      height_q <= H_MAX;
      count_q  <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      count_q  <= count_d;
    end
  end

  grm_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_cell)
  );

  grm_merge #(
    .MASK_WIDTH_MAX  (MASK_WIDTH_MAX),
    .MASK_HEIGHT_MAX (MASK_HEIGHT_MAX)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kick_i       (kick),
    .width_i      (width_eff),
    .height_i     (height_eff),
    .rd_addr_o    (rd_addr),
    .clr_we_o     (clr_we),
    .rd_data_i    (rd_cell),
    .busy_o       (merge_busy),
    .out_strobe_o (rect_strobe_o),
    .out_rect_o   (rect)
  );

  assign busy            = merge_busy;
  assign rect_valid_o    = rect.valid;
  assign u_start_o       = rect.u_start;
  assign v_start_o       = rect.v_start;
  assign u_end_o         = rect.u_end;
  assign v_end_o         = rect.v_end;
  assign rect_tile_col_o = rect.tile_col;
  assign rect_tile_row_o = rect.tile_row;
  assign last_rect_o     = rect.last;

  assign rect_zero = (u_start_o == '0) && (v_start_o == '0) && (u_end_o == '0) &&
                     (v_end_o == '0) && (rect_tile_col_o == '0) && (rect_tile_row_o == '0);

  `GRM_ASSERT(a_busy_from_kick, clk_i, rst_ni, $rose(busy) |-> $past(start && !busy), "busy rose without an accepted word")
  `GRM_ASSERT(a_last_ends_merge, clk_i, rst_ni, rect_strobe_o |-> (last_rect_o == !busy), "last flag out of step")
  `GRM_ASSERT(a_empty_is_zero, clk_i, rst_ni, (rect_strobe_o && !rect_valid_o) |-> (last_rect_o && rect_zero), "empty word not clean")
  `GRM_ASSERT_NEVER(a_rect_order, clk_i, rst_ni, rect_strobe_o && rect_valid_o && (u_end_o < u_start_o || v_end_o < v_start_o), "corners reversed")

endmodule

`default_nettype wire
